### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Operation and status codes, field widths and the default ring depth.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 16;

    // Operation requested by an input transfer
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SHOW       = 3'd4
    } t_op;

    // Status carried by each result transfer
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

### design/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read data, hold it between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Values live in a ring RAM addressed by a front index and an entry count.
// Push and pop touch one entry; show walks every stored entry front to back.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata           tuser          tlast
//  s        in   value[31:0]     operation[2:0] -
//  m        out  data[31:0]      status[1:0]    last result of the item
//
// A push, a full push and any empty report leave the block ready for the next
// item in the following cycle unless the output is stalled. A pop waits in
// S_POP for the value read from the registered RAM port. A show reads the
// entries one at a time through the single read port, front to back.
// Reset clears the front index, the entry count and the control state; the walk pointers and the RAM are not cleared.
// A stalled output holds its result, and the block takes no new item until
// every result of the current one has entered the output register.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // value
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic signed [dq_pkg::DATA_W-1:0] i_s_tdata,
    // operation
    input  logic [dq_pkg::OP_W-1:0]          i_s_tuser,
    // data
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic signed [dq_pkg::DATA_W-1:0] o_m_tdata,
    // status
    output logic [dq_pkg::ST_W-1:0]          o_m_tuser,
    output logic                             o_m_tlast
);

    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HOLD = 4'b0010,
        S_POP  = 4'b0100,
        S_SHOW = 4'b1000
    } t_state;

    // Fold a sum below twice the depth back onto the ring
    function automatic logic [IW-1:0] f_wrap(input logic [CW:0] sum);
        logic [CW:0] red;
        red = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
        return red[IW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [IW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_left, n_left;
    t_status           r_hold, n_hold;

    logic                     r_m_valid;
    logic signed [DATA_W-1:0] r_m_data;
    t_status                  r_m_status;
    logic                     r_m_last;

    t_op                      op;
    logic                     s_acc;
    logic                     out_free;
    logic                     empty;
    logic                     full;
    logic [IW-1:0]            front_dec;
    logic [IW-1:0]            front_inc;
    logic [IW-1:0]            ptr_inc;
    logic [IW-1:0]            pos_back;
    logic [IW-1:0]            pos_last;

    logic                     ld;
    t_status                  ld_status;
    logic signed [DATA_W-1:0] ld_data;
    logic                     ld_last;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;

    assign op        = t_op'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc     = i_s_tvalid && o_s_tready;
    assign out_free  = !r_m_valid || i_m_tready;
    assign empty     = (r_count == '0);
    assign full      = (r_count == FULL_C);

    // Ring positions next to the front and the back
    assign front_dec = (r_front == '0) ? LAST_IX : r_front - 1'b1;
    assign front_inc = f_wrap((CW + 1)'(r_front) + 1'b1);
    assign ptr_inc   = f_wrap((CW + 1)'(r_rd_ptr) + 1'b1);
    assign pos_back  = f_wrap((CW + 1)'(r_front) + (CW + 1)'(r_count));
    assign pos_last  = f_wrap((CW + 1)'(r_front) + (CW + 1)'(r_count) - 1'b1);

    // Entry store; writes happen only on accept and reads never overlap them
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Decode the operation and sequence reads, writes and results
    always_comb begin
        logic    imm_valid;
        t_status imm_status;

        imm_valid  = 1'b0;
        imm_status = ST_OK;
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_rd_ptr   = r_rd_ptr;
        n_left     = r_left;
        n_hold     = r_hold;
        ld         = 1'b0;
        ld_status  = ST_OK;
        ld_data    = '0;
        ld_last    = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = pos_back;
        rd_en      = 1'b0;
        rd_addr    = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            imm_valid = 1'b1;
                            if (full) begin
                                imm_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (op == OP_PUSH_FRONT) begin
                                    wr_addr = front_dec;
                                    n_front = front_dec;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                imm_valid  = 1'b1;
                                imm_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                                if (op == OP_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = front_inc;
                                end else begin
                                    rd_addr = pos_last;
                                end
                            end
                        end
                        OP_SHOW: begin
                            if (empty) begin
                                imm_valid  = 1'b1;
                                imm_status = ST_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_front;
                                n_rd_ptr = front_inc;
                                n_left   = r_count;
                                n_state  = S_SHOW;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Load a single result now, or park it until the output drains
                    if (imm_valid) begin
                        if (out_free) begin
                            ld        = 1'b1;
                            ld_status = imm_status;
                        end else begin
                            n_hold  = imm_status;
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_status = r_hold;
                    n_state   = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_data = rd_data;
                    n_state = S_IDLE;
                end
            end
            S_SHOW: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_data = rd_data;
                    ld_last = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = r_rd_ptr;
                        n_rd_ptr = ptr_inc;
                        n_left   = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (ld) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Hold walk pointers and the output payload
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_left   <= n_left;
        r_hold   <= n_hold;
        if (ld) begin
            r_m_status <= ld_status;
            r_m_data   <= ld_data;
            r_m_last   <= ld_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_status;
    assign o_m_tlast  = r_m_last;

    // An accepted push with room grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the entry count");

    // A show walk never has more left than is stored
    a_show_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> (r_left != '0 && r_left <= r_count))
        else $error("show walk count out of range");

    // Error results carry zero data and close the item
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status != ST_OK) |-> (r_m_last && r_m_data == '0))
        else $error("error result without last or with data");

endmodule
